### hw/rtl/tdi_pkg.sv
`timescale 1ns / 1ps

package tdi_pkg;

  parameter int COORD_FRAC_BITS  = 4;
  parameter int WEIGHT_FRAC_BITS = 16;

  parameter int COORD_W  = 16;
  parameter int DEPTH_W  = 32;
  parameter int WEIGHT_W = 32;

  parameter int DIFF_W  = COORD_W + 1;
  parameter int PROD_W  = 2 * DIFF_W;
  parameter int CROSS_W = PROD_W + 1;
  parameter int SUM_W   = PROD_W + 2;
  parameter int MAG_W   = SUM_W;
  parameter int DEN_W   = CROSS_W;
  parameter int REM_W   = DEN_W;
  parameter int NUM_W   = MAG_W + WEIGHT_FRAC_BITS;

  // A non-degenerate divisor is at least 2^(2*COORD_FRAC_BITS), which bounds the quotient.
  parameter int Q_W        = NUM_W - 2 * COORD_FRAC_BITS;
  parameter int DIV_STAGES = Q_W;
  parameter int QS_W       = Q_W + 1;

  parameter int SAT_W = 2 * WEIGHT_W + 2;
  parameter int MUL_W = DEPTH_W + WEIGHT_W;

  parameter int IN_TDATA_W  = 8 * COORD_W + 3 * DEPTH_W;
  parameter int OUT_FIELD_W = 4 * WEIGHT_W + 2;
  parameter int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  parameter logic signed [CROSS_W-1:0] DEGEN_THR = CROSS_W'(1) << (2 * COORD_FRAC_BITS);
  parameter logic signed [WEIGHT_W-1:0] W_ONE = WEIGHT_W'(1) << WEIGHT_FRAC_BITS;
  parameter logic signed [WEIGHT_W-1:0] W_NEG_ONE = -W_ONE;

  typedef struct packed {
    logic                            degen;
    logic [2:0]                      neg;
    logic [2:0][DEPTH_W-1:0]         depth;
  } tdi_side_t;

  function automatic logic signed [WEIGHT_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'({1'b0, {(WEIGHT_W-1){1'b1}}});
    lo = -hi - SAT_W'(1);
    if (v > hi) begin
      sat_word = {1'b0, {(WEIGHT_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_word = {1'b1, {(WEIGHT_W-1){1'b0}}};
    end else begin
      sat_word = v[WEIGHT_W-1:0];
    end
  endfunction

endpackage

### hw/rtl/tdi_div_pipe.sv
`timescale 1ns / 1ps

// Three restoring dividers sharing one divisor, one quotient bit per stage.
module tdi_div_pipe (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  logic [2:0][tdi_pkg::MAG_W-1:0]         num_i,
  input  logic [tdi_pkg::DEN_W-1:0]              den_i,
  input  tdi_pkg::tdi_side_t                     side_i,
  output logic                                   valid_o,
  output logic [2:0][tdi_pkg::Q_W-1:0]           quot_o,
  output tdi_pkg::tdi_side_t                     side_o
);

  localparam int NS = tdi_pkg::DIV_STAGES;
  localparam int RW = tdi_pkg::REM_W;
  localparam int QW = tdi_pkg::Q_W;
  localparam int MW = tdi_pkg::MAG_W;
  localparam int WF = tdi_pkg::WEIGHT_FRAC_BITS;

  logic [NS-1:0]              vld_q;
  logic [2:0][RW-1:0]         rem_q  [NS];
  logic [2:0][QW-1:0]         quo_q  [NS];
  logic [2:0][MW-1:0]         mag_q  [NS];
  logic [tdi_pkg::DEN_W-1:0]  den_q  [NS];
  tdi_pkg::tdi_side_t         side_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int NB = QW - 1 - k;
    logic                       vld_in;
    logic [2:0][RW-1:0]         rem_in;
    logic [2:0][QW-1:0]         quo_in;
    logic [2:0][MW-1:0]         mag_in;
    logic [tdi_pkg::DEN_W-1:0]  den_in;
    tdi_pkg::tdi_side_t         side_in;
    logic [2:0][RW-1:0]         rem_d;
    logic [2:0][QW-1:0]         quo_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign quo_in  = '0;
      assign mag_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      for (genvar j = 0; j < 3; j++) begin : g_init
        assign rem_in[j] = RW'(num_i[j] >> (QW - WF));
      end
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign mag_in  = mag_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic          nbit;
      logic [RW:0]   shifted;
      logic [RW+1:0] diff;
      if (NB >= WF) begin : g_numbit
        assign nbit = mag_in[j][NB-WF];
      end else begin : g_zerobit
        assign nbit = 1'b0;
      end
      assign shifted = {rem_in[j], nbit};
      assign diff    = {1'b0, shifted} - {2'b00, den_in};
      assign rem_d[j] = diff[RW+1] ? shifted[RW-1:0] : diff[RW-1:0];
      assign quo_d[j] = {quo_in[j][QW-2:0], ~diff[RW+1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        mag_q[k]  <= mag_in;
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign quot_o  = quo_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

### hw/rtl/triangle_depth_interpolator.sv
`timescale 1ns / 1ps
// A result passes through 4 setup stages, 44 divider stages with one quotient bit each,
// and 4 weight and depth stages.
// Throughput: one transfer per cycle; the whole pipeline holds while a result waits.
// Reset clears all valid bits; data registers are not reset.

module triangle_depth_interpolator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // point_x, point_y, vert0_x, vert0_y, vert0_depth, vert1_x, vert1_y, vert1_depth,
  // vert2_x, vert2_y, vert2_depth
  input  logic [tdi_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // weight_first, weight_second, weight_third, depth_out, inside_res, degenerate, zero pad
  output logic [tdi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);

  localparam int CW = tdi_pkg::COORD_W;
  localparam int DW = tdi_pkg::DEPTH_W;
  localparam int WW = tdi_pkg::WEIGHT_W;
  localparam int XW = tdi_pkg::DIFF_W;
  localparam int PW = tdi_pkg::PROD_W;
  localparam int UW = tdi_pkg::CROSS_W;
  localparam int SW = tdi_pkg::SUM_W;
  localparam int TW = tdi_pkg::SAT_W;

  logic en;
  assign en = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input unpacking.
  logic signed [CW-1:0] px, py, x0, y0, x1, y1, x2, y2;
  logic [2:0][DW-1:0]   din;
  assign px     = s_axis_tdata_i[CW-1:0];
  assign py     = s_axis_tdata_i[2*CW-1:CW];
  assign x0     = s_axis_tdata_i[3*CW-1:2*CW];
  assign y0     = s_axis_tdata_i[4*CW-1:3*CW];
  assign din[0] = s_axis_tdata_i[4*CW+DW-1:4*CW];
  assign x1     = s_axis_tdata_i[5*CW+DW-1:4*CW+DW];
  assign y1     = s_axis_tdata_i[6*CW+DW-1:5*CW+DW];
  assign din[1] = s_axis_tdata_i[6*CW+2*DW-1:6*CW+DW];
  assign x2     = s_axis_tdata_i[7*CW+2*DW-1:6*CW+2*DW];
  assign y2     = s_axis_tdata_i[8*CW+2*DW-1:7*CW+2*DW];
  assign din[2] = s_axis_tdata_i[8*CW+3*DW-1:8*CW+2*DW];

  // Stage 1: edge differences.
  logic                 s1_vld_q;
  logic signed [XW-1:0] ax0_q, ax1_q, ax2_q, by0_q, by1_q, by2_q;
  logic [2:0][DW-1:0]   s1_dep_q;

  // Stage 2: cross product terms.
  logic                 s2_vld_q;
  logic signed [PW-1:0] pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic [2:0][DW-1:0]   s2_dep_q;

  // Stage 3: cross product.
  logic                 s3_vld_q;
  logic signed [UW-1:0] ux_q, uy_q, uz_q;
  logic signed [SW-1:0] uxy_q;
  logic [2:0][DW-1:0]   s3_dep_q;

  // Stage 4: magnitudes and signs for the dividers.
  logic                                s4_vld_q;
  logic [2:0][tdi_pkg::MAG_W-1:0]      s4_num_q;
  logic [tdi_pkg::DEN_W-1:0]           s4_den_q;
  tdi_pkg::tdi_side_t                  s4_side_q;

  logic signed [SW-1:0]           ux_ext, uy_ext;
  logic [2:0][tdi_pkg::MAG_W-1:0] s4_num_d;
  tdi_pkg::tdi_side_t             s4_side_d;

  assign ux_ext = SW'(ux_q);
  assign uy_ext = SW'(uy_q);
  assign s4_num_d[0] = uxy_q[SW-1] ? tdi_pkg::MAG_W'(-uxy_q) : tdi_pkg::MAG_W'(uxy_q);
  assign s4_num_d[1] = uy_ext[SW-1] ? tdi_pkg::MAG_W'(-uy_ext) : tdi_pkg::MAG_W'(uy_ext);
  assign s4_num_d[2] = ux_ext[SW-1] ? tdi_pkg::MAG_W'(-ux_ext) : tdi_pkg::MAG_W'(ux_ext);
  assign s4_side_d.degen = (uz_q > -tdi_pkg::DEGEN_THR) && (uz_q < tdi_pkg::DEGEN_THR);
  assign s4_side_d.neg[0] = uxy_q[SW-1] ^ uz_q[UW-1];
  assign s4_side_d.neg[1] = uy_q[UW-1] ^ uz_q[UW-1];
  assign s4_side_d.neg[2] = ux_q[UW-1] ^ uz_q[UW-1];
  assign s4_side_d.depth = s3_dep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax0_q    <= XW'(x2) - XW'(x0);
      ax1_q    <= XW'(x1) - XW'(x0);
      ax2_q    <= XW'(x0) - XW'(px);
      by0_q    <= XW'(y2) - XW'(y0);
      by1_q    <= XW'(y1) - XW'(y0);
      by2_q    <= XW'(y0) - XW'(py);
      s1_dep_q <= din;

      pa_q     <= PW'(ax1_q) * PW'(by2_q);
      pb_q     <= PW'(ax2_q) * PW'(by1_q);
      pc_q     <= PW'(ax2_q) * PW'(by0_q);
      pd_q     <= PW'(ax0_q) * PW'(by2_q);
      pe_q     <= PW'(ax0_q) * PW'(by1_q);
      pf_q     <= PW'(ax1_q) * PW'(by0_q);
      s2_dep_q <= s1_dep_q;

      ux_q     <= UW'(pa_q) - UW'(pb_q);
      uy_q     <= UW'(pc_q) - UW'(pd_q);
      uz_q     <= UW'(pe_q) - UW'(pf_q);
      uxy_q    <= SW'(pa_q) - SW'(pb_q) + SW'(pc_q) - SW'(pd_q);
      s3_dep_q <= s2_dep_q;

      s4_num_q  <= s4_num_d;
      s4_den_q  <= uz_q[UW-1] ? tdi_pkg::DEN_W'(-uz_q) : tdi_pkg::DEN_W'(uz_q);
      s4_side_q <= s4_side_d;
    end
  end

  logic                            dv_vld;
  logic [2:0][tdi_pkg::Q_W-1:0]    dv_quot;
  tdi_pkg::tdi_side_t              dv_side;

  tdi_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_vld_q),
    .num_i   (s4_num_q),
    .den_i   (s4_den_q),
    .side_i  (s4_side_q),
    .valid_o (dv_vld),
    .quot_o  (dv_quot),
    .side_o  (dv_side)
  );

  // Stage 5: signed, saturated weights.
  logic signed [tdi_pkg::QS_W-1:0] qs0, qs1, qs2;
  assign qs0 = dv_side.neg[0] ? -tdi_pkg::QS_W'(dv_quot[0]) : tdi_pkg::QS_W'(dv_quot[0]);
  assign qs1 = dv_side.neg[1] ? -tdi_pkg::QS_W'(dv_quot[1]) : tdi_pkg::QS_W'(dv_quot[1]);
  assign qs2 = dv_side.neg[2] ? -tdi_pkg::QS_W'(dv_quot[2]) : tdi_pkg::QS_W'(dv_quot[2]);

  logic                 s5_vld_q, s6_vld_q, s7_vld_q;
  logic signed [WW-1:0] w0_q, w1_q, w2_q;
  logic                 s5_degen_q;
  logic [2:0][DW-1:0]   s5_dep_q;

  logic signed [tdi_pkg::MUL_W-1:0] m0_q, m1_q, m2_q;
  logic signed [WW-1:0]             s6_w0_q, s6_w1_q, s6_w2_q;
  logic                             s6_degen_q;

  logic signed [TW-1:0] sum_q;
  logic signed [WW-1:0] s7_w0_q, s7_w1_q, s7_w2_q;
  logic                 s7_degen_q;

  logic                 out_vld_q;
  logic signed [WW-1:0] ow0_q, ow1_q, ow2_q, odep_q;
  logic                 oins_q, odeg_q;
  logic signed [TW-1:0] sum_shift;
  assign sum_shift = sum_q >>> tdi_pkg::WEIGHT_FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q  <= dv_vld;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      out_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dv_side.degen) begin
        w0_q <= tdi_pkg::W_NEG_ONE;
        w1_q <= tdi_pkg::W_ONE;
        w2_q <= tdi_pkg::W_ONE;
      end else begin
        w0_q <= tdi_pkg::sat_word(TW'(tdi_pkg::W_ONE) - TW'(qs0));
        w1_q <= tdi_pkg::sat_word(TW'(qs1));
        w2_q <= tdi_pkg::sat_word(TW'(qs2));
      end
      s5_degen_q <= dv_side.degen;
      s5_dep_q   <= dv_side.depth;

      m0_q       <= $signed(s5_dep_q[0]) * w0_q;
      m1_q       <= $signed(s5_dep_q[1]) * w1_q;
      m2_q       <= $signed(s5_dep_q[2]) * w2_q;
      s6_w0_q    <= w0_q;
      s6_w1_q    <= w1_q;
      s6_w2_q    <= w2_q;
      s6_degen_q <= s5_degen_q;

      sum_q      <= TW'(m0_q) + TW'(m1_q) + TW'(m2_q);
      s7_w0_q    <= s6_w0_q;
      s7_w1_q    <= s6_w1_q;
      s7_w2_q    <= s6_w2_q;
      s7_degen_q <= s6_degen_q;

      ow0_q  <= s7_w0_q;
      ow1_q  <= s7_w1_q;
      ow2_q  <= s7_w2_q;
      odep_q <= tdi_pkg::sat_word(sum_shift);
      oins_q <= !s7_w0_q[WW-1] && !s7_w1_q[WW-1] && !s7_w2_q[WW-1];
      odeg_q <= s7_degen_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = tdi_pkg::OUT_TDATA_W'({odeg_q, oins_q, odep_q, ow2_q, ow1_q, ow0_q});

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic signed [tdi_pkg::DEPTH_W-1:0] d2;
    logic signed [tdi_pkg::COORD_W-1:0] y2;
    logic signed [tdi_pkg::COORD_W-1:0] x2;
    logic signed [tdi_pkg::DEPTH_W-1:0] d1;
    logic signed [tdi_pkg::COORD_W-1:0] y1;
    logic signed [tdi_pkg::COORD_W-1:0] x1;
    logic signed [tdi_pkg::DEPTH_W-1:0] d0;
    logic signed [tdi_pkg::COORD_W-1:0] y0;
    logic signed [tdi_pkg::COORD_W-1:0] x0;
    logic signed [tdi_pkg::COORD_W-1:0] py;
    logic signed [tdi_pkg::COORD_W-1:0] px;
  } tri_item_t;

  typedef struct packed {
    logic                                degen;
    logic                                in_tri;
    logic signed [tdi_pkg::WEIGHT_W-1:0] depth;
    logic signed [tdi_pkg::WEIGHT_W-1:0] w2;
    logic signed [tdi_pkg::WEIGHT_W-1:0] w1;
    logic signed [tdi_pkg::WEIGHT_W-1:0] w0;
  } interp_t;

  typedef struct {
    tri_item_t item;
    logic      has_known;
    interp_t   known;
  } directed_row_t;

  localparam int LATENCY      = 52;
  localparam int RANDOM_ITEMS = 1530;
  localparam int STALL_LIMIT  = 20000;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid_i;
  logic s_axis_tready_o;
  logic [tdi_pkg::IN_TDATA_W-1:0] s_axis_tdata_i;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i;
  logic [tdi_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  interp_t       expected_q[$];
  directed_row_t directed_rows[$];
  int  error_count;
  int  results_seen;
  int  degen_seen;
  int  inside_seen;
  int  idle_cycles;
  int  sender_idle_pct;
  int  receiver_stall_pct;
  logic hold_off;
  logic timed_out;

  triangle_depth_interpolator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [tdi_pkg::WEIGHT_W-1:0] clamp_word(
      input logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -128'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Barycentric weights and interpolated depth, done at full width.
  function automatic interp_t interpolate(input tri_item_t t);
    interp_t r;
    logic signed [127:0] one, thr, ax0, ax1, ax2, by0, by1, by2, ux, uy, uz, acc;
    one = 128'sd1 <<< tdi_pkg::WEIGHT_FRAC_BITS;
    thr = 128'sd1 <<< (2 * tdi_pkg::COORD_FRAC_BITS);
    ax0 = 128'(t.x2) - 128'(t.x0);
    ax1 = 128'(t.x1) - 128'(t.x0);
    ax2 = 128'(t.x0) - 128'(t.px);
    by0 = 128'(t.y2) - 128'(t.y0);
    by1 = 128'(t.y1) - 128'(t.y0);
    by2 = 128'(t.y0) - 128'(t.py);
    ux = ax1 * by2 - ax2 * by1;
    uy = ax2 * by0 - ax0 * by2;
    uz = ax0 * by1 - ax1 * by0;
    r.degen = (uz > -thr) && (uz < thr);
    if (r.degen) begin
      r.w0 = tdi_pkg::W_NEG_ONE;
      r.w1 = tdi_pkg::W_ONE;
      r.w2 = tdi_pkg::W_ONE;
    end else begin
      // SystemVerilog signed division truncates toward zero.
      r.w0 = clamp_word(one - ((ux + uy) * one) / uz);
      r.w1 = clamp_word((uy * one) / uz);
      r.w2 = clamp_word((ux * one) / uz);
    end
    acc = 128'(t.d0) * 128'(r.w0) + 128'(t.d1) * 128'(r.w1) + 128'(t.d2) * 128'(r.w2);
    r.depth = clamp_word(acc >>> tdi_pkg::WEIGHT_FRAC_BITS);
    r.in_tri = !r.w0[31] && !r.w1[31] && !r.w2[31];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH result %0d %s: got %h, want %h", results_seen, field, got, want);
    error_count++;
  endtask

  function automatic tri_item_t random_triangle(input int mode);
    tri_item_t t;
    t = tri_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (mode == 1) begin
      // Small triangles around the point so the inside case is common.
      t.x0 = t.px + 16'($signed($urandom_range(0, 400)) - 200);
      t.y0 = t.py + 16'($signed($urandom_range(0, 400)) - 200);
      t.x1 = t.px + 16'($signed($urandom_range(0, 400)) - 200);
      t.y1 = t.py + 16'($signed($urandom_range(0, 400)) - 200);
      t.x2 = t.px + 16'($signed($urandom_range(0, 400)) - 200);
      t.y2 = t.py + 16'($signed($urandom_range(0, 400)) - 200);
    end else if (mode == 2) begin
      // Collinear or nearly collinear vertices.
      t.x1 = t.x0 + 16'($urandom_range(0, 3));
      t.y1 = t.y0 + 16'($urandom_range(0, 3));
      t.x2 = t.x1 + 16'($urandom_range(0, 3));
      t.y2 = t.y1 + 16'($urandom_range(0, 3));
    end
    return t;
  endfunction

  function automatic tri_item_t make_item(input logic signed [15:0] px, py, x0, y0, x1, y1,
                                          x2, y2, input logic signed [31:0] d0, d1, d2);
    tri_item_t t;
    t.px = px; t.py = py;
    t.x0 = x0; t.y0 = y0; t.d0 = d0;
    t.x1 = x1; t.y1 = y1; t.d1 = d1;
    t.x2 = x2; t.y2 = y2; t.d2 = d2;
    return t;
  endfunction

  task automatic add_row(input tri_item_t t, input logic has_known, input interp_t known);
    directed_row_t row;
    row.item = t;
    row.has_known = has_known;
    row.known = known;
    directed_rows.push_back(row);
  endtask

  // Valid stays high into the next item when there is no idle gap.
  task automatic send_item(input tri_item_t t, input interp_t want);
    while (sender_idle_pct > 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= t;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_q.push_back(want);
  endtask

  // Receiver side: random stalls plus an optional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= !hold_off &&
                         !(receiver_stall_pct > 0 &&
                           $urandom_range(1, 100) <= receiver_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    interp_t got;
    interp_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = interp_t'(m_axis_tdata_o[tdi_pkg::OUT_FIELD_W-1:0]);
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected", 64'(got.depth), 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.w0 !== want.w0) report_mismatch("weight_first", 64'(got.w0), 64'(want.w0));
        if (got.w1 !== want.w1) report_mismatch("weight_second", 64'(got.w1), 64'(want.w1));
        if (got.w2 !== want.w2) report_mismatch("weight_third", 64'(got.w2), 64'(want.w2));
        if (got.depth !== want.depth) begin
          report_mismatch("depth_out", 64'(got.depth), 64'(want.depth));
        end
        if (got.in_tri !== want.in_tri) begin
          report_mismatch("inside_res", 64'(got.in_tri), 64'(want.in_tri));
        end
        if (got.degen !== want.degen) report_mismatch("degenerate", 64'(got.degen), 64'(want.degen));
      end
      results_seen++;
      degen_seen  += want.degen;
      inside_seen += want.in_tri;
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni && (s_axis_tvalid_i || expected_q.size() > 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        timed_out <= 1'b1;
      end
    end
  end

  initial begin
    timed_out = 1'b0;
    wait (timed_out);
    $display("Watchdog expired with %0d results outstanding", expected_q.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tri_item_t t;
    interp_t   k;
    int        phase;
    int        waited;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    hold_off = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    error_count = 0;
    results_seen = 0;
    degen_seen = 0;
    inside_seen = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. Degenerate rows give weights (-1, 1, 1) at a glance.
    k.w0 = tdi_pkg::W_NEG_ONE; k.w1 = tdi_pkg::W_ONE; k.w2 = tdi_pkg::W_ONE;
    k.in_tri = 1'b0; k.degen = 1'b1;
    k.depth = 32'sd0;
    add_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, k);
    k.depth = 32'sh0001_0000;
    add_row(make_item(16'sh7fff, 16'sh8000, 5, 5, 5, 5, 5, 5, 32'sh0001_0000,
                      32'sh0001_0000, 32'sh0001_0000), 1'b1, k);
    k.depth = 32'sh7fff_ffff;
    add_row(make_item(0, 0, 0, 0, 1, 1, 2, 2, 32'sh8000_0000, 32'sh7fff_ffff,
                      32'sh7fff_ffff), 1'b1, k);
    k.depth = 32'sh8000_0000;
    add_row(make_item(0, 0, 0, 0, 1, 0, 2, 0, 32'sh7fff_ffff, 32'sh8000_0000,
                      32'sh8000_0000), 1'b1, k);
    // Determinants of at most 1/16 in magnitude, below the degeneracy threshold of 1.0.
    add_row(make_item(0, 0, 0, 0, 16, 0, 0, 1, 0, 0, 0), 1'b0, k);
    add_row(make_item(0, 0, 0, 0, 15, 0, 0, 1, 0, 0, 0), 1'b0, k);
    add_row(make_item(0, 0, 0, 0, -16, 0, 0, 1, 0, 0, 0), 1'b0, k);
    add_row(make_item(16, 16, 0, 0, 160, 0, 0, 160, 32'sh0001_0000, 32'sh0002_0000,
                      32'sh0003_0000), 1'b0, k);
    add_row(make_item(0, 0, 0, 0, 160, 0, 0, 160, -5, 7, 9), 1'b0, k);
    add_row(make_item(500, 500, 0, 0, 160, 0, 0, 160, 32'sh7fff_ffff, 32'sh8000_0000,
                      32'sh7fff_ffff), 1'b0, k);
    add_row(make_item(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
                      16'sh7fff, 16'sh8000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh8000_0000), 1'b0, k);
    add_row(make_item(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
                      16'sh7fff, 16'sh8000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                      32'sh7fff_ffff), 1'b0, k);
    add_row(make_item(16'sh7fff, 16'sh8000, 0, 0, 16, 0, 0, 16, 32'sh7fff_ffff, -1, 1),
            1'b0, k);
    add_row(make_item(16'sh8000, 16'sh7fff, 0, 0, -16, 0, 0, 17, -1, -1, -1), 1'b0, k);
    add_row(make_item(-1, -1, -1, -1, -1, 16'sh7fff, 16'sh7fff, -1, -1, -1, -1), 1'b0, k);
    add_row(make_item(0, 0, 0, 0, 1, 300, 300, 1, 32'sh5555_5555, 32'shaaaa_aaaa,
                      32'sh1234_5678), 1'b0, k);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].item,
                directed_rows[i].has_known ? directed_rows[i].known
                                           : interpolate(directed_rows[i].item));
    end

    // Random phases: none, sender idle, receiver stalls, both, and a long hold-off.
    for (phase = 0; phase < 5; phase++) begin
      sender_idle_pct    = (phase == 1) ? 87 : (phase == 3) ? 25 : 0;
      receiver_stall_pct = (phase == 2) ? 87 : (phase == 3) ? 25 : 0;
      if (phase == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (RANDOM_ITEMS / 5) begin
        t = random_triangle($urandom_range(0, 9) < 5 ? 1 : ($urandom_range(0, 4) == 0 ? 2 : 0));
        send_item(t, interpolate(t));
      end
    end
    s_axis_tvalid_i <= 1'b0;

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    waited = 0;
    while (expected_q.size() > 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Checked %0d results: %0d degenerate, %0d inside, across idle and stall phases",
             results_seen, degen_seen, inside_seen);
    $display("including a long output hold-off that back-pressured the input.");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
